// File: src/ifd_pkg.sv
// Shared types and constants for the IR frame extract decoder.
package ifd_pkg;

  localparam int DUR_W = 31;
  localparam int CODE_W = 32;
  localparam int LEN_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [LEN_W-1:0] MAX_FRAME_ELEMENTS = 8'd128;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 3'd4;

  // reset values
  localparam logic [DUR_W-1:0] HEADER_RST = 31'd4000;
  localparam logic [DUR_W-1:0] ONE_RST = 31'd1000;
  localparam logic [DUR_W-1:0] GAP_RST = 31'd10000;
  localparam logic [DUR_W-1:0] TIMEOUT_RST = 31'd20000;
  localparam logic [LEN_W-1:0] MIN_LEN_RST = 8'd6;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_IDLE = 1'b1;

  // result kind codes
  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0] header_threshold;
    logic [DUR_W-1:0] one_threshold;
    logic [DUR_W-1:0] gap_threshold;
    logic [DUR_W-1:0] timeout_threshold;
    logic [LEN_W-1:0] min_frame_length;
  } ifd_cfg_t;

  typedef struct packed {
    logic kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0] frame_length;
  } ifd_res_t;

endpackage

// File: src/ifd_cfg.sv
// Configuration register bank.
module ifd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ifd_pkg::ifd_cfg_t                 cfg
);
  import ifd_pkg::*;

  ifd_cfg_t cfg_r;
  ifd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:  cfg_nxt.header_threshold = cfg_wdata;
        REG_ONE:     cfg_nxt.one_threshold = cfg_wdata;
        REG_GAP:     cfg_nxt.gap_threshold = cfg_wdata;
        REG_TIMEOUT: cfg_nxt.timeout_threshold = cfg_wdata;
        REG_MIN_LEN: cfg_nxt.min_frame_length = cfg_wdata[LEN_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_threshold <= HEADER_RST;
      cfg_r.one_threshold <= ONE_RST;
      cfg_r.gap_threshold <= GAP_RST;
      cfg_r.timeout_threshold <= TIMEOUT_RST;
      cfg_r.min_frame_length <= MIN_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/ifd_core.sv
// Frame tracking state and single-pass decode of one registered duration.
module ifd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          mode,
  input  logic [ifd_pkg::DUR_W-1:0]     duration,
  input  ifd_pkg::ifd_cfg_t             cfg,
  output logic                          res_valid,
  output ifd_pkg::ifd_res_t             res
);
  import ifd_pkg::*;

  logic              hunting_r, hunting_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]  count_inc;
  logic [CODE_W-1:0] acc_shift;
  logic              odd_data;

  assign count_inc = count_r + LEN_W'(1);
  assign odd_data = count_r[0] && (duration < cfg.header_threshold);
  assign acc_shift = {acc_r[CODE_W-2:0], (duration >= cfg.one_threshold)};

  always_comb begin
    hunting_nxt = hunting_r;
    count_nxt = count_r;
    acc_nxt = acc_r;
    res_valid = 1'b0;
    res.kind = KIND_CODE;
    res.code = acc_r;
    res.frame_length = count_r;
    if (mode == MODE_IDLE) begin
      if (!hunting_r && (count_r != '0) && (duration >= cfg.timeout_threshold)) begin
        hunting_nxt = 1'b1;
        res_valid = (count_r > cfg.min_frame_length);
      end
    end else if (hunting_r) begin
      if (duration > cfg.timeout_threshold) begin
        hunting_nxt = 1'b0;
        count_nxt = '0;
        acc_nxt = '0;
      end
    end else if (count_r >= MAX_FRAME_ELEMENTS) begin
      hunting_nxt = 1'b1;
      res_valid = 1'b1;
      res.kind = KIND_OVERFLOW;
      res.code = '0;
      res.frame_length = MAX_FRAME_ELEMENTS;
    end else begin
      if (odd_data) begin
        acc_nxt = acc_shift;
      end
      count_nxt = count_inc;
      res.code = acc_nxt;
      res.frame_length = count_inc;
      if ((duration > cfg.gap_threshold) || (duration == '0)) begin
        hunting_nxt = 1'b1;
        res_valid = (count_inc > cfg.min_frame_length);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      count_r <= '0;
      acc_r <= '0;
    end else if (advance) begin
      hunting_r <= hunting_nxt;
      count_r <= count_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: src/ir_frame_extract_decoder_core.sv
// Top level of the IR frame extract decoder.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_mode, in_duration
//   out_     output     out_valid / out_ready out_kind, out_code, out_frame_length
//   cfg_     input      cfg_we (no wait)      cfg_index, cfg_wdata
//
// One transaction per cycle sustained while no stalled result holds the flow.
// An item passes the input register, then the decode into the result register.
// Reset (rst_n low, synchronous) clears the valid flags, frame state and
// loads the register defaults.
// A stalled result only holds back an item that itself makes a result; items
// that make none keep flowing past a waiting result.
module ir_frame_extract_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [ifd_pkg::DUR_W-1:0]       in_duration,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [ifd_pkg::CODE_W-1:0]      out_code,
  output logic [ifd_pkg::LEN_W-1:0]       out_frame_length,
  input  logic                            cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ifd_pkg::*;

  ifd_cfg_t cfg;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_mode_r;
  logic [DUR_W-1:0] s1_dur_r;

  // result register
  logic     out_valid_r, out_valid_nxt;
  ifd_res_t out_res_r;

  logic     res_valid;
  ifd_res_t res;
  logic     advance;
  logic     in_fire;

  ifd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .mode      (s1_mode_r),
    .duration  (s1_dur_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // the held item moves on unless it has a result and the result slot is full
  assign advance = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || advance);
  assign in_fire = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_dur_r <= in_duration;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_res_r.kind;
  assign out_code = out_res_r.code;
  assign out_frame_length = out_res_r.frame_length;

endmodule

// File: src/ifd_checker.sv
// Port-level assertions for the IR frame extract decoder, bound to the top level.
module ifd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_kind,
  input logic [ifd_pkg::CODE_W-1:0]      out_code,
  input logic [ifd_pkg::LEN_W-1:0]       out_frame_length
);
  import ifd_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_kind)
      && $stable(out_frame_length))
    else $error("result changed while stalled");

  // overflow reports carry a zero code and the full length
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_OVERFLOW) |->
      (out_code == '0) && (out_frame_length == MAX_FRAME_ELEMENTS))
    else $error("malformed overflow result");

  // a frame never holds more than the limit, nor zero elements
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_length <= MAX_FRAME_ELEMENTS) && (out_frame_length != '0))
    else $error("frame length out of range");

  // a fresh result follows an accepted transaction via the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching transaction");

endmodule

bind ir_frame_extract_decoder_core ifd_checker u_ifd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_code         (out_code),
  .out_frame_length (out_frame_length)
);

// File: tb/tb_ir_frame_extract_decoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IR frame extract decoder core.
module tb_ir_frame_extract_decoder_core;
  import ifd_pkg::*;

  // Two register stages from input to result; a few spare cycles on top.
  localparam int LATENCY = 2;
  // Cycles without any transaction or register write before giving up.
  // The worst honest pause is an input gap plus an output stall
  // plus a register update.
  localparam int STUCK_LIMIT = 500;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;
  // Total items to send, closing stretch included, and results wanted.
  // The random phases stop once both of these are reached or MAX_PHASES run out.
  localparam int unsigned RAND_ITEMS = 400;
  localparam int unsigned RESULTS_WANTED = 40;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned FINAL_ITEMS = 40;
  localparam int MAX_PHASES = 60;

  typedef struct packed {
    logic mode;
    logic [DUR_W-1:0] duration;
  } ir_item_t;

  // DUT ports; the driven inputs are all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_SAMPLE;
  logic [DUR_W-1:0] in_duration = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0] out_frame_length;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the register file, updated as writes are issued.
  logic [DUR_W-1:0] hdr_thr = HEADER_RST;
  logic [DUR_W-1:0] one_thr = ONE_RST;
  logic [DUR_W-1:0] gap_thr = GAP_RST;
  logic [DUR_W-1:0] tmo_thr = TIMEOUT_RST;
  logic [LEN_W-1:0] min_len = MIN_LEN_RST;

  // Mirror of the frame tracker.
  logic hunting = 1'b1;
  logic [LEN_W-1:0] elem_cnt = '0;
  logic [CODE_W-1:0] code_acc = '0;

  ir_item_t durations_to_send[$];
  ifd_res_t frames_expected[$];
  ir_item_t next_item;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned rand_items = 0;
  int unsigned results_seen = 0;
  int unsigned n_errors = 0;
  int unsigned stuck_cycles = 0;
  int in_gap_left = 0;
  int out_stall_left = 0;
  logic in_gaps_on = 1'b0;
  logic out_stalls_on = 1'b0;
  int phase_no;

  ir_frame_extract_decoder_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_duration      (in_duration),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_code         (out_code),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Frame tracker mirror
  // ---------------------------------------------------------------------

  // Frame over: report it if it is long enough, go back to hunting.
  task automatic close_frame();
    ifd_res_t r;
    if (elem_cnt > min_len) begin
      r.kind = KIND_CODE;
      r.code = code_acc;
      r.frame_length = elem_cnt;
      frames_expected.push_back(r);
    end
    hunting = 1'b1;
  endtask

  // Advance the mirror by one accepted transaction.
  task automatic decode_duration(input logic mode, input logic [DUR_W-1:0] d);
    ifd_res_t r;
    if (mode == MODE_IDLE) begin
      // idle check only closes a frame that already holds something
      if (!hunting && elem_cnt != '0 && d >= tmo_thr) close_frame();
    end else if (hunting) begin
      // start marker is not part of the frame
      if (d > tmo_thr) begin
        hunting = 1'b0;
        elem_cnt = '0;
        code_acc = '0;
      end
    end else if (elem_cnt >= MAX_FRAME_ELEMENTS) begin
      // frame buffer full: sample dropped, frame dropped, error reported
      hunting = 1'b1;
      r.kind = KIND_OVERFLOW;
      r.code = '0;
      r.frame_length = MAX_FRAME_ELEMENTS;
      frames_expected.push_back(r);
    end else begin
      // odd positions carry data unless they look like a header
      if (elem_cnt[0] && d < hdr_thr) code_acc = {code_acc[CODE_W-2:0], d >= one_thr};
      elem_cnt = elem_cnt + 1'b1;
      if (d > gap_thr || d == '0) close_frame();
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic int unsigned pick_range(input int unsigned lo, input int unsigned hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Value at or above lo: half the time just past it, else anywhere up to max.
  function automatic int unsigned at_or_above(input int unsigned lo);
    if ($urandom_range(1, 0) != 0) return pick_range(lo, min_u(lo + 100, DUR_MAX));
    return pick_range(lo, DUR_MAX);
  endfunction

  // Frame element that does not end the frame: short, long or header-ish.
  function automatic int unsigned body_duration();
    int unsigned g = gap_thr;
    int unsigned one = one_thr;
    int unsigned hdr = hdr_thr;
    int unsigned v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: v = pick_range(1, min_u((one == 0) ? 1 : one - 1, g));
      4, 5, 6, 7: v = pick_range(one, min_u((hdr == 0) ? one : hdr - 1, g));
      8:          v = pick_range(hdr, g);
      default:    v = pick_range(1, g);
    endcase
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic int unsigned any_threshold();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return DUR_MAX;
      default: return $urandom & DUR_MAX;
    endcase
  endfunction

  task automatic push_item(input logic mode, input int unsigned d);
    ir_item_t it;
    it.mode = mode;
    it.duration = DUR_W'(d);
    durations_to_send.push_back(it);
    n_queued++;
  endtask

  // One framed burst: start marker, elements, then a terminator. Lengths past
  // the buffer size run the frame into overflow instead.
  task automatic gen_frame(input int unsigned len);
    int unsigned n_body;
    n_body = (len > MAX_FRAME_ELEMENTS) ? MAX_FRAME_ELEMENTS : len - 1;
    push_item(MODE_SAMPLE, (tmo_thr == DUR_MAX) ? DUR_MAX : at_or_above(tmo_thr + 1));
    for (int unsigned i = 0; i < n_body; i++) begin
      // harmless idle check now and then, elapsed still short
      if (tmo_thr != '0 && $urandom_range(15, 0) == 0)
        push_item(MODE_IDLE, pick_range(0, tmo_thr - 1));
      push_item(MODE_SAMPLE, body_duration());
    end
    if (len > MAX_FRAME_ELEMENTS) begin
      push_item(MODE_SAMPLE, $urandom & DUR_MAX);
    end else begin
      case ($urandom_range(3, 0))
        0: push_item(MODE_SAMPLE, 0);
        1: push_item(MODE_IDLE, at_or_above(tmo_thr));
        default: push_item(MODE_SAMPLE, (gap_thr == DUR_MAX) ? 0 : at_or_above(gap_thr + 1));
      endcase
    end
    rand_items += n_body + 2;
  endtask

  // Mostly reportable lengths, some short ones, a few that fill the buffer.
  function automatic int unsigned frame_length_pick();
    int unsigned r = $urandom_range(19, 0);
    int unsigned m = min_len;
    if (r == 0) return ($urandom_range(1, 0) != 0) ? MAX_FRAME_ELEMENTS : MAX_FRAME_ELEMENTS + 1;
    if (r < 5) return pick_range(1, m);
    return min_u(m + pick_range(1, 12), MAX_FRAME_ELEMENTS + 1);
  endfunction

  task automatic run_phase(input int unsigned budget);
    int unsigned first = rand_items;
    while (rand_items - first < budget) begin
      // occasional junk between frames: random mode, edge-heavy values
      if ($urandom_range(3, 0) == 0) begin
        for (int k = $urandom_range(3, 1); k > 0; k--) begin
          case ($urandom_range(3, 0))
            0:       push_item(1'($urandom_range(1, 0)), 0);
            1:       push_item(1'($urandom_range(1, 0)), DUR_MAX);
            2:       push_item(1'($urandom_range(1, 0)), tmo_thr);
            default: push_item(1'($urandom_range(1, 0)), $urandom & DUR_MAX);
          endcase
        end
      end
      gen_frame(frame_length_pick());
    end
  endtask

  // ---------------------------------------------------------------------
  // Register access (only while the block is idle)
  // ---------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    case (idx)
      REG_HEADER:  hdr_thr = DUR_W'(data);
      REG_ONE:     one_thr = DUR_W'(data);
      REG_GAP:     gap_thr = DUR_W'(data);
      REG_TIMEOUT: tmo_thr = DUR_W'(data);
      REG_MIN_LEN: min_len = LEN_W'(data);
      default: ;
    endcase
  endtask

  // Upper data bits are junk; only the low byte counts.
  task automatic write_min_len(input int unsigned m);
    write_reg(REG_MIN_LEN, ($urandom << LEN_W) | m);
  endtask

  task automatic configure(input int sel);
    int unsigned a;
    int unsigned b;
    case (sel)
      0: ; // keep reset values
      1: begin
        // ordered thresholds: one < header < gap <= timeout
        a = pick_range(1, 5000);
        b = a + pick_range(1, 5000);
        write_reg(REG_ONE, a);
        write_reg(REG_HEADER, b);
        a = b + pick_range(1, 20000);
        write_reg(REG_GAP, a);
        write_reg(REG_TIMEOUT, a + pick_range(0, 20000));
        write_min_len(pick_range(0, 16));
      end
      2: begin
        // all zero: every nonzero sample starts, every element ends a frame
        write_reg(REG_HEADER, 0);
        write_reg(REG_ONE, 0);
        write_reg(REG_GAP, 0);
        write_reg(REG_TIMEOUT, 0);
        write_min_len(0);
      end
      3: begin
        // top of range: only the largest value starts, gap never trips
        write_reg(REG_HEADER, DUR_MAX);
        write_reg(REG_ONE, pick_range(1, DUR_MAX));
        write_reg(REG_GAP, DUR_MAX);
        write_reg(REG_TIMEOUT, DUR_MAX - 1);
        write_min_len(0);
      end
      4: begin
        // longest minimum: only an overflow gets out
        write_reg(REG_HEADER, HEADER_RST);
        write_reg(REG_ONE, ONE_RST);
        write_reg(REG_GAP, GAP_RST);
        write_reg(REG_TIMEOUT, TIMEOUT_RST);
        write_min_len(MAX_FRAME_ELEMENTS);
      end
      5: begin
        // default thresholds again, plus writes to unmapped indexes that must be dropped
        write_reg(REG_HEADER, HEADER_RST);
        write_reg(REG_ONE, ONE_RST);
        write_reg(REG_GAP, GAP_RST);
        write_reg(REG_TIMEOUT, TIMEOUT_RST);
        write_min_len(pick_range(0, 10));
        for (int i = int'(REG_MIN_LEN) + 1; i < (1 << CFG_IDX_W); i++)
          write_reg(CFG_IDX_W'(i), $urandom);
      end
      default: begin
        // unordered, edge-heavy thresholds
        write_reg(REG_HEADER, any_threshold());
        write_reg(REG_ONE, any_threshold());
        write_reg(REG_GAP, any_threshold());
        write_reg(REG_TIMEOUT, any_threshold());
        write_min_len(pick_range(0, MAX_FRAME_ELEMENTS));
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every sent item to be taken and every result to come back, then
  // give items that make no result time to leave the pipeline.
  task automatic settle();
    while (n_accepted != n_queued || frames_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: one item per transaction, random gap bursts
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // holding the current item until it is taken
    end else if (in_gap_left > 0) begin
      in_gap_left <= in_gap_left - 1;
      in_valid <= 1'b0;
    end else if (durations_to_send.size() != 0 && in_gaps_on && $urandom_range(7, 0) == 0) begin
      in_gap_left <= $urandom_range(18, 1) - 1;
      in_valid <= 1'b0;
    end else if (durations_to_send.size() != 0) begin
      next_item = durations_to_send.pop_front();
      in_valid <= 1'b1;
      in_mode <= next_item.mode;
      in_duration <= next_item.duration;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side back-pressure, random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(7, 0) == 0) begin
      out_stall_left <= $urandom_range(18, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------

  // Every accepted input transaction advances the mirror.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      decode_duration(in_mode, in_duration);
      n_accepted++;
    end
  end

  // Every accepted result is checked against the oldest expected frame.
  always @(posedge clk) begin
    ifd_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (frames_expected.size() == 0) begin
        $error("unexpected result: kind %0d code 0x%08h frame_length %0d",
               out_kind, out_code, out_frame_length);
        n_errors++;
      end else begin
        want = frames_expected.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          n_errors++;
        end
        if (out_code !== want.code) begin
          $error("code: expected 0x%08h, got 0x%08h", want.code, out_code);
          n_errors++;
        end
        if (out_frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, out_frame_length);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $error("no progress for %0d cycles", STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;

    // Directed pass on reset values (one 1000, header 4000, gap 10000,
    // timeout 20000, min length 6).
    push_item(MODE_IDLE, DUR_MAX);      // idle check while hunting
    push_item(MODE_SAMPLE, 0);          // zero while hunting
    push_item(MODE_SAMPLE, 20000);      // equal to timeout: no start
    push_item(MODE_SAMPLE, 20001);      // start
    push_item(MODE_IDLE, 0);            // idle check, empty frame
    push_item(MODE_SAMPLE, 500);        // even position, no bit
    push_item(MODE_SAMPLE, 1500);       // bit one
    push_item(MODE_IDLE, 19999);        // elapsed short of timeout
    push_item(MODE_SAMPLE, 999);
    push_item(MODE_SAMPLE, 999);        // just under one: bit zero
    push_item(MODE_SAMPLE, 1000);
    push_item(MODE_SAMPLE, 1000);       // at one: bit one
    push_item(MODE_SAMPLE, 3999);
    push_item(MODE_SAMPLE, 4000);       // at header: no bit
    push_item(MODE_SAMPLE, 10000);      // at gap: frame goes on
    push_item(MODE_SAMPLE, 3999);       // just under header: bit one
    push_item(MODE_SAMPLE, 10001);      // above gap: reported frame
    push_item(MODE_SAMPLE, DUR_MAX);    // start on the largest value
    push_item(MODE_SAMPLE, 1);
    push_item(MODE_SAMPLE, 2000);
    push_item(MODE_SAMPLE, 0);          // zero ends a short frame
    push_item(MODE_SAMPLE, DUR_MAX);
    push_item(MODE_SAMPLE, 500);
    push_item(MODE_IDLE, 20000);        // idle at timeout ends a short frame
    settle();

    // Random phases, each under its own register setting and idle pattern.
    phase_no = 0;
    while ((n_queued + FINAL_ITEMS < RAND_ITEMS || results_seen < RESULTS_WANTED) &&
           phase_no < MAX_PHASES) begin
      configure((phase_no == 0) ? 0 : 1 + (phase_no - 1) % 6);
      in_gaps_on = ($urandom_range(3, 0) != 0);
      out_stalls_on = ($urandom_range(3, 0) != 0);
      run_phase(PHASE_ITEMS);
      settle();
      phase_no++;
    end

    // Closing stretch at full rate on both sides.
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    configure(1);
    run_phase(FINAL_ITEMS);
    settle();

    if (frames_expected.size() != 0) begin
      $error("%0d expected results never arrived", frames_expected.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
